// ----- rtl/core/tfc_pkg.sv -----
// Shared types, constants and helpers of the timestamp frame cache.
package tfc_pkg;

    localparam int ENTRIES  = 64;
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int TOTAL_W  = 32 + $clog2(ENTRIES);
    localparam int BUDGET_W = 38;
    localparam int SPAN_W   = 31;

    localparam logic [BUDGET_W-1:0] BUDGET_RESET = BUDGET_W'(268435456);

    localparam logic [1:0] CMD_PUT    = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_TRIM   = 2'd3;

    typedef struct packed {
        logic [63:0]       start;
        logic [SPAN_W-1:0] span;
        logic [31:0]       size;
        logic [31:0]       handle;
    } entry_t;

    typedef struct packed {
        logic below;
        logic eq;
        logic le;
    } cell_flags_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REPLACE,
        OP_SHIFT
    } cell_op_t;

    // Signed less-than on two's complement stamps.
    function automatic logic s_less(input logic [63:0] a, input logic [63:0] b);
        return $signed(a) < $signed(b);
    endfunction

endpackage

// ----- rtl/core/tfc_cell.sv -----
// One slot of the sorted entry row, shifting to and from its neighbors.
module tfc_cell (
    input  logic                 clk,
    input  tfc_pkg::cell_op_t    op,
    input  tfc_pkg::entry_t      new_entry,
    input  tfc_pkg::entry_t      left_entry,
    input  tfc_pkg::entry_t      right_entry,
    input  logic                 left_before,
    input  logic                 in_range,
    input  logic [63:0]          pts,
    output tfc_pkg::entry_t      entry,
    output tfc_pkg::cell_flags_t flags
);

    tfc_pkg::entry_t entry_reg;

    always_comb
    begin
        flags.below = in_range && tfc_pkg::s_less(entry_reg.start, pts);
        flags.eq    = in_range && (entry_reg.start == pts);
        flags.le    = in_range && !tfc_pkg::s_less(pts, entry_reg.start);
    end

    always_ff @(posedge clk)
    begin
        case (op)
            tfc_pkg::OP_INSERT:
            begin
                // The first slot not before the new stamp takes the new word,
                // every later slot takes its left neighbor.
                if (!flags.below)
                begin
                    if (left_before)
                        entry_reg <= new_entry;
                    else
                        entry_reg <= left_entry;
                end
            end
            tfc_pkg::OP_REPLACE:
            begin
                if (flags.eq)
                    entry_reg <= new_entry;
            end
            tfc_pkg::OP_SHIFT:
                entry_reg <= right_entry;
            default:
                entry_reg <= entry_reg;
        endcase
    end

    assign entry = entry_reg;

endmodule

// ----- rtl/core/timestamp_frame_cache.sv -----
// Top level of the timestamp frame cache: cell row, sequencer and register port.
//
// Input words (cmd, pts, duration, frame_bytes, frame_handle, frame_valid) enter
// on in_valid/in_ready; one result word per input word leaves on
// out_valid/out_ready. The byte budget is written through the APB-style port
// at address 0 and can be read back.
// Entries live in a row of cells sorted by start stamp; inserts shift the row
// right, evictions of the oldest entry shift it left, all cells at once.
// A clear goes straight to the result word. A put is first checked in the put
// state: an invalid put ends there, a put that matches a start replaces that
// entry, and a put of a new start is inserted; both then go to the budget check,
// as a trim does. A lookup finds the entry, then tests whether its span holds the
// stamp. Each budget eviction selects the ends, measures distances, removes one end
// and rechecks; the eviction that makes room in a full table goes on to the insert.
// One word is worked on at a time; in_ready is high whenever the sequencer is
// idle, even while a finished result still waits in the output register.
// If the receiver stalls, the result holds and a second finished result waits
// in the sequencer until the output register frees.
// Reset empties the table, forgets the last request and sets the budget to
// 268435456 bytes; entry contents are not cleared.
module timestamp_frame_cache (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [63:0] pts,
    input  logic [31:0] duration,
    input  logic [31:0] frame_bytes,
    input  logic [31:0] frame_handle,
    input  logic        frame_valid,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        status,
    output logic        hit,
    output logic        covers,
    output logic [31:0] found_handle,
    output logic [6:0]  entry_count,
    output logic [37:0] total_bytes,
    output logic [6:0]  evicted_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int N = tfc_pkg::ENTRIES;
    localparam int SPAN_W_PAD = tfc_pkg::SPAN_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUT,
        S_PUT_INS,
        S_LOOK,
        S_LOOK2,
        S_TRIM_CHK,
        S_EV_SEL,
        S_EV_DIST,
        S_EV_DO,
        S_OUT
    } state_t;

    state_t state_reg;

    logic [tfc_pkg::BUDGET_W-1:0] budget_reg;
    logic [tfc_pkg::CNT_W-1:0]    count_reg;
    logic [tfc_pkg::TOTAL_W-1:0]  total_reg;
    logic [63:0]                  last_asked_reg;
    logic                         asked_yet_reg;

    logic [1:0]                   cmd_reg;
    logic [63:0]                  pts_reg;
    logic                         fvalid_reg;
    tfc_pkg::entry_t              new_reg;
    logic                         put_pending_reg;

    logic [63:0]                  first_start_reg;
    logic [63:0]                  last_start_reg;
    logic [31:0]                  first_size_reg;
    logic [31:0]                  last_size_reg;
    logic [63:0]                  d0_reg;
    logic [63:0]                  d1_reg;
    tfc_pkg::entry_t              sel_reg;

    logic                         res_status_reg;
    logic                         res_hit_reg;
    logic                         res_covers_reg;
    logic [tfc_pkg::CNT_W-1:0]    res_evicted_reg;

    logic                         out_valid_reg;
    logic                         status_reg;
    logic                         hit_reg;
    logic                         covers_reg;
    logic [31:0]                  handle_reg;
    logic [6:0]                   count_out_reg;
    logic [37:0]                  total_out_reg;
    logic [6:0]                   evicted_out_reg;

    tfc_pkg::entry_t              cell_entry [N];
    tfc_pkg::cell_flags_t         cell_flags [N];
    logic [N-1:0]                 in_range;
    tfc_pkg::cell_op_t            cell_op;

    logic                         any_eq;
    logic [31:0]                  eq_size;
    tfc_pkg::entry_t              last_entry;
    tfc_pkg::entry_t              found_entry;
    logic                         evict_first;
    logic [63:0]                  ref_stamp;
    logic                         cfg_write;
    logic [SPAN_W_PAD-1:0]        span_in;

    // Negative or zero durations become one.
    assign span_in = (duration[31] || duration == 32'd0) ? SPAN_W_PAD'(1)
                                                         : duration[SPAN_W_PAD-1:0];

    assign evict_first = (d0_reg >= d1_reg);

    always_comb
    begin
        case (state_reg)
            S_PUT:     cell_op = (fvalid_reg && any_eq) ? tfc_pkg::OP_REPLACE
                                                        : tfc_pkg::OP_HOLD;
            S_PUT_INS: cell_op = tfc_pkg::OP_INSERT;
            S_EV_DO:   cell_op = evict_first ? tfc_pkg::OP_SHIFT : tfc_pkg::OP_HOLD;
            default:   cell_op = tfc_pkg::OP_HOLD;
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            assign in_range[g] = (tfc_pkg::CNT_W'(g) < count_reg);

            tfc_cell u_cell (
                .clk         (clk),
                .op          (cell_op),
                .new_entry   (new_reg),
                .left_entry  ((g == 0) ? new_reg : cell_entry[(g == 0) ? 0 : g - 1]),
                .right_entry ((g == N - 1) ? cell_entry[g] : cell_entry[(g == N - 1) ? g : g + 1]),
                .left_before ((g == 0) ? 1'b1 : cell_flags[(g == 0) ? 0 : g - 1].below),
                .in_range    (in_range[g]),
                .pts         (pts_reg),
                .entry       (cell_entry[g]),
                .flags       (cell_flags[g])
            );
        end
    endgenerate

    // One-hot selections over the row, merged by OR.
    always_comb
    begin
        logic is_last;
        logic is_found;
        any_eq      = 1'b0;
        eq_size     = '0;
        last_entry  = '0;
        found_entry = '0;
        for (int i = 0; i < N; i++)
        begin
            if (i == N - 1)
            begin
                is_last  = in_range[i];
                is_found = cell_flags[i].le;
            end
            else
            begin
                is_last  = in_range[i] && !in_range[i + 1];
                is_found = cell_flags[i].le && !cell_flags[i + 1].le;
            end
            any_eq      = any_eq | cell_flags[i].eq;
            eq_size     = eq_size | (cell_entry[i].size & {32{cell_flags[i].eq}});
            last_entry  = last_entry | (cell_entry[i] & {$bits(tfc_pkg::entry_t){is_last}});
            found_entry = found_entry | (cell_entry[i] & {$bits(tfc_pkg::entry_t){is_found}});
        end
    end

    assign ref_stamp = asked_yet_reg ? last_asked_reg : last_start_reg;

    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr[3] == 1'b0) ? 64'(budget_reg) : 64'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            budget_reg      <= tfc_pkg::BUDGET_RESET;
            count_reg       <= '0;
            total_reg       <= '0;
            last_asked_reg  <= '0;
            asked_yet_reg   <= 1'b0;
            put_pending_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write && paddr[3] == 1'b0)
                budget_reg <= pwdata[tfc_pkg::BUDGET_W-1:0];

            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg         <= cmd;
                        pts_reg         <= pts;
                        fvalid_reg      <= frame_valid;
                        new_reg.start   <= pts;
                        new_reg.span    <= span_in;
                        new_reg.size    <= frame_bytes;
                        new_reg.handle  <= frame_handle;
                        res_status_reg  <= 1'b0;
                        res_hit_reg     <= 1'b0;
                        res_covers_reg  <= 1'b0;
                        sel_reg         <= '0;
                        res_evicted_reg <= '0;
                        case (cmd)
                            tfc_pkg::CMD_PUT:    state_reg <= S_PUT;
                            tfc_pkg::CMD_LOOKUP: state_reg <= S_LOOK;
                            tfc_pkg::CMD_CLEAR:
                            begin
                                count_reg <= '0;
                                total_reg <= '0;
                                state_reg <= S_OUT;
                            end
                            default:             state_reg <= S_TRIM_CHK;
                        endcase
                    end
                end
                S_PUT:
                begin
                    if (!fvalid_reg)
                    begin
                        res_status_reg <= 1'b1;
                        state_reg      <= S_OUT;
                    end
                    else if (any_eq)
                    begin
                        total_reg <= total_reg - tfc_pkg::TOTAL_W'(eq_size)
                                   + tfc_pkg::TOTAL_W'(new_reg.size);
                        state_reg <= S_TRIM_CHK;
                    end
                    else if (count_reg == tfc_pkg::CNT_W'(N))
                    begin
                        put_pending_reg <= 1'b1;
                        state_reg       <= S_EV_SEL;
                    end
                    else
                        state_reg <= S_PUT_INS;
                end
                S_PUT_INS:
                begin
                    count_reg <= count_reg + 1'b1;
                    total_reg <= total_reg + tfc_pkg::TOTAL_W'(new_reg.size);
                    state_reg <= S_TRIM_CHK;
                end
                S_LOOK:
                begin
                    last_asked_reg <= pts_reg;
                    asked_yet_reg  <= 1'b1;
                    res_hit_reg    <= cell_flags[0].le;
                    sel_reg        <= found_entry;
                    state_reg      <= S_LOOK2;
                end
                S_LOOK2:
                begin
                    // Start is at or before the stamp, so the difference is nonnegative.
                    res_covers_reg <= res_hit_reg &&
                                      ((pts_reg - sel_reg.start) < 64'(sel_reg.span));
                    state_reg      <= S_OUT;
                end
                S_TRIM_CHK:
                begin
                    if (64'(total_reg) > 64'(budget_reg) && count_reg > tfc_pkg::CNT_W'(1))
                        state_reg <= S_EV_SEL;
                    else
                        state_reg <= S_OUT;
                end
                S_EV_SEL:
                begin
                    first_start_reg <= cell_entry[0].start;
                    first_size_reg  <= cell_entry[0].size;
                    last_start_reg  <= last_entry.start;
                    last_size_reg   <= last_entry.size;
                    state_reg       <= S_EV_DIST;
                end
                S_EV_DIST:
                begin
                    d0_reg    <= tfc_pkg::s_less(ref_stamp, first_start_reg)
                                 ? first_start_reg - ref_stamp : ref_stamp - first_start_reg;
                    d1_reg    <= tfc_pkg::s_less(ref_stamp, last_start_reg)
                                 ? last_start_reg - ref_stamp : ref_stamp - last_start_reg;
                    state_reg <= S_EV_DO;
                end
                S_EV_DO:
                begin
                    total_reg       <= total_reg - tfc_pkg::TOTAL_W'(evict_first ? first_size_reg
                                                                                 : last_size_reg);
                    count_reg       <= count_reg - 1'b1;
                    res_evicted_reg <= res_evicted_reg + 1'b1;
                    put_pending_reg <= 1'b0;
                    state_reg       <= put_pending_reg ? S_PUT_INS : S_TRIM_CHK;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg   <= 1'b1;
                        status_reg      <= res_status_reg;
                        hit_reg         <= res_hit_reg;
                        covers_reg      <= res_covers_reg;
                        handle_reg      <= res_hit_reg ? sel_reg.handle : 32'd0;
                        count_out_reg   <= 7'(count_reg);
                        total_out_reg   <= 38'(total_reg);
                        evicted_out_reg <= 7'(res_evicted_reg);
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign hit           = hit_reg;
    assign covers        = covers_reg;
    assign found_handle  = handle_reg;
    assign entry_count   = count_out_reg;
    assign total_bytes   = total_out_reg;
    assign evicted_count = evicted_out_reg;

endmodule

// ----- rtl/core/tfc_checker.sv -----
// Port-level checks of the timestamp frame cache, bound to the top level.
module tfc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        status,
    input logic        hit,
    input logic        covers,
    input logic [31:0] found_handle,
    input logic [6:0]  entry_count,
    input logic [6:0]  evicted_count
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(entry_count)
                                    && $stable(found_handle) && $stable(status))
        else $error("result word changed while stalled");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entry_count <= 7'(tfc_pkg::ENTRIES))
        else $error("entry count above table size");

    a_ignored_put: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> evicted_count == 7'd0 && !hit)
        else $error("ignored put reported evictions or a hit");

    a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> !covers && found_handle == 32'd0)
        else $error("miss reported coverage or a handle");

endmodule

bind timestamp_frame_cache tfc_checker u_tfc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .hit           (hit),
    .covers        (covers),
    .found_handle  (found_handle),
    .entry_count   (entry_count),
    .evicted_count (evicted_count)
);

// ----- sim/tb_timestamp_frame_cache.sv -----
// Self-checking testbench of the timestamp frame cache: directed words, then random traffic.
`timescale 1ns / 1ps

module tb_timestamp_frame_cache;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  cmd;
    logic [63:0] pts;
    logic [31:0] duration;
    logic [31:0] frame_bytes;
    logic [31:0] frame_handle;
    logic        frame_valid;
    logic        out_valid;
    logic        out_ready;
    logic        status;
    logic        hit;
    logic        covers;
    logic [31:0] found_handle;
    logic [6:0]  entry_count;
    logic [37:0] total_bytes;
    logic [6:0]  evicted_count;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    localparam logic [3:0] ADDR_BYTE_BUDGET = 4'd0;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [1:0]  c;
        logic [63:0] p;
        logic [31:0] d;
        logic [31:0] b;
        logic [31:0] h;
        logic        v;
    } word_t;

    typedef struct packed {
        logic        st;
        logic        ht;
        logic        cv;
        logic [31:0] fh;
        logic [6:0]  ec;
        logic [37:0] tb;
        logic [6:0]  ev;
    } reply_t;

    typedef struct {
        word_t  w;
        logic   known;
        reply_t r;
    } row_t;

    timestamp_frame_cache dut (.*);

    // Shadow copy of the cache table.
    logic [63:0] sh_start [tfc_pkg::ENTRIES];
    logic [30:0] sh_span  [tfc_pkg::ENTRIES];
    logic [31:0] sh_size  [tfc_pkg::ENTRIES];
    logic [31:0] sh_hdl   [tfc_pkg::ENTRIES];
    int          sh_count;
    logic [63:0] sh_bytes;
    logic [63:0] sh_asked;
    logic        sh_asked_yet;
    logic [37:0] sh_budget;

    reply_t replies_due [$];
    int     errors;
    int     checked;
    int     cycles;
    int     send_idle_pct;
    int     recv_stall_pct;

    function automatic logic [63:0] stamp_dist(logic [63:0] a, logic [63:0] b);
        return ($signed(b) < $signed(a)) ? a - b : b - a;
    endfunction

    function automatic void drop_at(int i);
        sh_bytes = sh_bytes - sh_size[i];
        for (int k = i; k < sh_count - 1; k++)
        begin
            sh_start[k] = sh_start[k+1];
            sh_span[k]  = sh_span[k+1];
            sh_size[k]  = sh_size[k+1];
            sh_hdl[k]   = sh_hdl[k+1];
        end
        sh_count--;
    endfunction

    function automatic void evict_far_end();
        logic [63:0] ref_stamp;
        int last;
        last = sh_count - 1;
        ref_stamp = sh_asked_yet ? sh_asked : sh_start[last];
        if (stamp_dist(sh_start[0], ref_stamp) >= stamp_dist(sh_start[last], ref_stamp))
            drop_at(0);
        else
            drop_at(last);
    endfunction

    function automatic int trim_to_budget();
        int n;
        n = 0;
        while (sh_bytes > {26'd0, sh_budget} && sh_count > 1)
        begin
            evict_far_end();
            n++;
        end
        return n;
    endfunction

    function automatic int find_slot(logic [63:0] p);
        int pos;
        pos = 0;
        while (pos < sh_count && $signed(sh_start[pos]) < $signed(p))
            pos++;
        return pos;
    endfunction

    function automatic reply_t cache_step(word_t w);
        reply_t r;
        int pos;
        int cnt;
        int ev;
        logic [30:0] span;
        r = '0;
        ev = 0;
        if (w.c == tfc_pkg::CMD_PUT)
        begin
            if (!w.v)
                r.st = 1'b1;
            else
            begin
                span = (w.d[31] || w.d == 0) ? 31'd1 : w.d[30:0];
                pos = find_slot(w.p);
                if (pos < sh_count && sh_start[pos] == w.p)
                    sh_bytes = sh_bytes - sh_size[pos];
                else
                begin
                    if (sh_count >= tfc_pkg::ENTRIES)
                    begin
                        evict_far_end();
                        ev++;
                        pos = find_slot(w.p);
                    end
                    for (int k = sh_count; k > pos; k--)
                    begin
                        sh_start[k] = sh_start[k-1];
                        sh_span[k]  = sh_span[k-1];
                        sh_size[k]  = sh_size[k-1];
                        sh_hdl[k]   = sh_hdl[k-1];
                    end
                    sh_count++;
                end
                sh_start[pos] = w.p;
                sh_span[pos]  = span;
                sh_size[pos]  = w.b;
                sh_hdl[pos]   = w.h;
                sh_bytes = sh_bytes + w.b;
                ev += trim_to_budget();
            end
        end
        else if (w.c == tfc_pkg::CMD_LOOKUP)
        begin
            sh_asked = w.p;
            sh_asked_yet = 1'b1;
            cnt = 0;
            while (cnt < sh_count && !($signed(w.p) < $signed(sh_start[cnt])))
                cnt++;
            if (cnt > 0)
            begin
                r.ht = 1'b1;
                r.fh = sh_hdl[cnt-1];
                r.cv = (w.p - sh_start[cnt-1]) < {33'd0, sh_span[cnt-1]};
            end
        end
        else if (w.c == tfc_pkg::CMD_CLEAR)
        begin
            sh_count = 0;
            sh_bytes = 0;
        end
        else
            ev = trim_to_budget();
        r.ec = sh_count[6:0];
        r.tb = sh_bytes[37:0];
        r.ev = ev[6:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("ERROR t=%0t word %0d: %s got %0h expected %0h", $time, checked, what,
                 got, want);
        errors++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: random stall and compare against the oldest expectation.
    always @(posedge clk)
    begin
        reply_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (replies_due.size() == 0)
                    report_mismatch("unexpected result word", 64'd1, 64'd0);
                else
                begin
                    e = replies_due.pop_front();
                    if (status !== e.st) report_mismatch("status", status, e.st);
                    if (hit !== e.ht) report_mismatch("hit", hit, e.ht);
                    if (covers !== e.cv) report_mismatch("covers", covers, e.cv);
                    if (found_handle !== e.fh)
                        report_mismatch("found_handle", found_handle, e.fh);
                    if (entry_count !== e.ec)
                        report_mismatch("entry_count", entry_count, e.ec);
                    if (total_bytes !== e.tb)
                        report_mismatch("total_bytes", total_bytes, e.tb);
                    if (evicted_count !== e.ev)
                        report_mismatch("evicted_count", evicted_count, e.ev);
                end
                checked++;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_word(word_t w, logic known, reply_t want);
        reply_t r;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        r = cache_step(w);
        if (known && r !== want)
            report_mismatch("directed row prediction", r[63:0], want[63:0]);
        replies_due.push_back(r);
        in_valid     <= 1'b1;
        cmd          <= w.c;
        pts          <= w.p;
        duration     <= w.d;
        frame_bytes  <= w.b;
        frame_handle <= w.h;
        frame_valid  <= w.v;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        // Leave the input idle between phases.
        repeat (4) @(posedge clk);
    endtask

    task automatic write_budget(logic [37:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_BYTE_BUDGET;
        pwdata  <= {26'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sh_budget = value;
    endtask

    function automatic word_t rand_word(int stamp_span, int mode);
        word_t w;
        int r;
        w.c = 2'($urandom_range(3));
        r = $urandom_range(99);
        if (r < 55) w.c = tfc_pkg::CMD_PUT;
        else if (r < 90) w.c = tfc_pkg::CMD_LOOKUP;
        else if (r < 93) w.c = tfc_pkg::CMD_CLEAR;
        else w.c = tfc_pkg::CMD_TRIM;
        if (mode == 0)
            w.p = 64'($signed(32'($urandom_range(2 * stamp_span))) - stamp_span);
        else
            w.p = {$urandom, $urandom};
        w.d = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(40));
        w.b = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(5000));
        w.h = $urandom;
        w.v = ($urandom_range(19) != 0);
        return w;
    endfunction

    initial
    begin
        row_t plan [$];
        row_t rw;
        word_t w;
        int phase_idle [4] = '{0, 83, 0, 9};
        int phase_stall [4] = '{0, 0, 83, 9};
        logic [37:0] budgets [4] = '{38'd0, 38'h3F_FFFF_FFFF, 38'd12000, 38'd3000};

        errors = 0; checked = 0; cycles = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        rst_n = 1'b0; in_valid = 1'b0; out_ready = 1'b0;
        cmd = tfc_pkg::CMD_PUT; pts = '0; duration = '0; frame_bytes = '0;
        frame_handle = '0;
        frame_valid = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        paddr = '0; pwdata = '0;
        sh_count = 0; sh_bytes = 0; sh_asked = 0; sh_asked_yet = 0;
        sh_budget = tfc_pkg::BUDGET_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: {cmd, pts, dur, bytes, handle, valid}, known, expected.
        plan.push_back('{'{tfc_pkg::CMD_LOOKUP, 64'd5, 32'd0, 32'd0, 32'd0, 1'b1}, 1'b1,
                         '{1'b0, 1'b0, 1'b0, 32'd0, 7'd0, 38'd0, 7'd0}});
        plan.push_back('{'{tfc_pkg::CMD_PUT, 64'd7, 32'd3, 32'd9, 32'hAA, 1'b0}, 1'b1,
                         '{1'b1, 1'b0, 1'b0, 32'd0, 7'd0, 38'd0, 7'd0}});
        plan.push_back('{'{tfc_pkg::CMD_PUT, 64'h8000_0000_0000_0000, 32'h8000_0000,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}, 1'b0, '0});
        plan.push_back('{'{tfc_pkg::CMD_PUT, 64'h7FFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 32'd0,
                           32'h1, 1'b1}, 1'b0, '0});
        plan.push_back('{'{tfc_pkg::CMD_PUT, 64'd0, 32'd0, 32'd100, 32'h55, 1'b1}, 1'b0, '0});
        plan.push_back('{'{tfc_pkg::CMD_LOOKUP, 64'h8000_0000_0000_0001, 32'd0, 32'd0, 32'd0,
                           1'b1}, 1'b0, '0});
        plan.push_back('{'{tfc_pkg::CMD_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0, 32'd0, 32'd0,
                           1'b1}, 1'b0, '0});
        plan.push_back('{'{tfc_pkg::CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 32'd0, 32'd0,
                           1'b1}, 1'b0, '0});
        plan.push_back('{'{tfc_pkg::CMD_PUT, 64'd0, 32'd50, 32'd200, 32'h66, 1'b1}, 1'b0, '0});
        plan.push_back('{'{tfc_pkg::CMD_LOOKUP, 64'd49, 32'd0, 32'd0, 32'd0, 1'b1}, 1'b0, '0});
        plan.push_back('{'{tfc_pkg::CMD_LOOKUP, 64'd50, 32'd0, 32'd0, 32'd0, 1'b1}, 1'b0, '0});
        plan.push_back('{'{tfc_pkg::CMD_TRIM, 64'd0, 32'd0, 32'd0, 32'd0, 1'b0}, 1'b0, '0});
        plan.push_back('{'{tfc_pkg::CMD_CLEAR, 64'd0, 32'd0, 32'd0, 32'd0, 1'b0}, 1'b1,
                         '{1'b0, 1'b0, 1'b0, 32'd0, 7'd0, 38'd0, 7'd0}});
        plan.push_back('{'{tfc_pkg::CMD_LOOKUP, 64'd1, 32'd0, 32'd0, 32'd0, 1'b1}, 1'b1,
                         '{1'b0, 1'b0, 1'b0, 32'd0, 7'd0, 38'd0, 7'd0}});
        foreach (plan[i])
            send_word(plan[i].w, plan[i].known, plan[i].r);
        drain();

        // Budget zero: the single remaining entry survives, others are evicted.
        write_budget(38'd0);
        for (int i = 0; i < 4; i++)
        begin
            w = '{tfc_pkg::CMD_PUT, 64'(i * 10 - 15), 32'd5, 32'd10, 32'(i), 1'b1};
            send_word(w, 1'b0, '0);
        end
        drain();
        write_budget(38'h3F_FFFF_FFFF);
        // Fill past capacity so a new start evicts a far end.
        for (int i = 0; i < tfc_pkg::ENTRIES + 6; i++)
        begin
            w = '{tfc_pkg::CMD_PUT, 64'($signed(i * 7 - 200)), 32'd3, 32'hFFFF_FFFF, 32'(i),
                  1'b1};
            send_word(w, 1'b0, '0);
        end
        w = '{tfc_pkg::CMD_LOOKUP, 64'($signed(-10000)), 32'd0, 32'd0, 32'd0, 1'b1};
        send_word(w, 1'b0, '0);
        w = '{tfc_pkg::CMD_PUT, 64'd900, 32'd3, 32'd1, 32'd77, 1'b1};
        send_word(w, 1'b0, '0);
        drain();
        write_budget(38'd20);
        w = '{tfc_pkg::CMD_TRIM, 64'd0, 32'd0, 32'd0, 32'd0, 1'b0};
        send_word(w, 1'b0, '0);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            write_budget(budgets[ph]);
            send_idle_pct = phase_idle[ph];
            recv_stall_pct = phase_stall[ph];
            for (int n = 0; n < 250; n++)
            begin
                send_word(rand_word(ph == 2 ? 30 : 400, ($urandom_range(9) == 0)), 1'b0,
                          '0);
                if (n == 120)
                    drain();
            end
            drain();
        end
        write_budget(tfc_pkg::BUDGET_RESET);

        $display("Covered put, lookup, clear and trim, full-table and budget eviction,");
        $display("%0d result words checked over four idle and stall phases", checked);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
